/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define BPF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define BPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bpf_pkg.sv */
// Types, constants and check/escape functions of the packet framer.
package bpf_pkg;

   localparam int BYTE_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int ACC_W     = 16;
   localparam int MASK_W    = 32;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;
   localparam int NUM_SLOTS = 10;

   localparam logic [BYTE_W-1:0] CH_DLE   = 8'h10;
   localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
   localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] LOW_ADJ  = 8'h40;
   localparam logic [BYTE_W-1:0] HIGH_ADJ = 8'h20;

   localparam logic [ACC_W-1:0]  CRC_POLY = 16'h1021;
   localparam logic [ACC_W-1:0]  CRC_INIT = 16'hFFFF;
   localparam logic [MASK_W-1:0] MASK_LOW_RESET  = 32'h002B_0028;
   localparam logic [MASK_W-1:0] MASK_HIGH_RESET = 32'h0000_0000;

   localparam logic [CSR_IDX_W-1:0] REG_CHECK_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUOTE_ALL  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_LOW   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MASK_HIGH  = 4'd3;

   // output slot order of one request
   localparam int SLOT_HDR_DLE = 0;
   localparam int SLOT_HDR_B   = 1;
   localparam int SLOT_DIGIT   = 2;
   localparam int SLOT_DAT_DLE = 3;
   localparam int SLOT_DAT     = 4;
   localparam int SLOT_ETX     = 5;
   localparam int SLOT_HI_DLE  = 6;
   localparam int SLOT_HI      = 7;
   localparam int SLOT_LO_DLE  = 8;
   localparam int SLOT_LO      = 9;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   typedef struct packed {
      logic              first;
      logic [BYTE_W-1:0] digit_char;
      logic [BYTE_W-1:0] dat;
      logic              dat_esc;
      logic              last;
      logic              crc;
      logic [BYTE_W-1:0] chk_hi;
      logic              hi_esc;
      logic [BYTE_W-1:0] chk_lo;
      logic              lo_esc;
   } job_type;

   typedef struct packed {
      logic              check_mode;
      logic              quote_all;
      logic [MASK_W-1:0] mask_low;
      logic [MASK_W-1:0] mask_high;
   } cfg_type;

   function automatic logic [ACC_W-1:0] chk_update(logic [ACC_W-1:0] acc,
                                                  logic [BYTE_W-1:0] b,
                                                  logic crc);
      logic [ACC_W-1:0]  c;
      logic [BYTE_W-1:0] r;
      logic [BYTE_W:0]   s;
      logic [BYTE_W-1:0] w;
      c = acc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[ACC_W-1] ? ({c[ACC_W-2:0], 1'b0} ^ CRC_POLY) : {c[ACC_W-2:0], 1'b0};
      end
      r = {acc[6:0], acc[7]};
      s = {1'b0, r} + {1'b0, b};
      w = s[BYTE_W] ? (s[BYTE_W-1:0] + 8'd1) : s[BYTE_W-1:0];
      return crc ? c : {8'h00, w};
   endfunction

   function automatic logic esc_need(logic [BYTE_W-1:0] b, cfg_type cfg);
      logic lo_rng;
      logic hi_rng;
      lo_rng = (b[7:5] == 3'b000);
      hi_rng = (b[7:5] == 3'b100);
      return (lo_rng && (cfg.quote_all || cfg.mask_low[b[4:0]])) ||
             (hi_rng && (cfg.quote_all || cfg.mask_high[b[4:0]]));
   endfunction

   function automatic logic [BYTE_W-1:0] esc_value(logic [BYTE_W-1:0] b, logic need);
      logic [BYTE_W-1:0] v;
      v = b;
      if (need) begin
         v = (b[7:5] == 3'b000) ? (b + LOW_ADJ) : (b - HIGH_ADJ);
      end
      return v;
   endfunction

endpackage

/* rtl/bpf_ifs.sv */
// Handshake interfaces for the request, response and CSR channels.
interface bpf_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpf_pkg::BYTE_W-1:0]    payload_byte;
   logic                          first_of_packet;
   logic                          last_of_packet;
   logic [bpf_pkg::DIGIT_W-1:0]   seq_digit;
   modport source (output valid, payload_byte, first_of_packet, last_of_packet, seq_digit,
                   input ready);
   modport sink   (input valid, payload_byte, first_of_packet, last_of_packet, seq_digit,
                   output ready);
endinterface

interface bpf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpf_pkg::BYTE_W-1:0]    tx_byte;
   logic                          run_last;
   logic                          frame_end;
   modport source (output valid, tx_byte, run_last, frame_end, input ready);
   modport sink   (input valid, tx_byte, run_last, frame_end, output ready);
endinterface

interface bpf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bpf_pkg::CSR_IDX_W-1:0]   index;
   logic [bpf_pkg::CSR_DAT_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bpf_front.sv */
// Front end: CSR registers, check accumulation and escape classification.
module bpf_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bpf_pkg::BYTE_W-1:0]      payload_byte,
   input  logic                            first_of_packet,
   input  logic                            last_of_packet,
   input  logic [bpf_pkg::DIGIT_W-1:0]     seq_digit,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpf_pkg::CSR_DAT_W-1:0]   csr_data,
   output logic                            push_valid,
   input  logic                            push_ready,
   output bpf_pkg::job_type                push_job
);

   bpf_pkg::cfg_type                cfg_ff, cfg_in;
   logic [bpf_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [bpf_pkg::ACC_W-1:0]       acc0, acc1, acc2, acc3;
   logic [bpf_pkg::BYTE_W-1:0]      digit_char;
   logic                            dat_esc, hi_esc, lo_esc;
   logic                            accept;

   assign req_ready  = push_ready;
   assign csr_ready  = 1'b1;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bpf_pkg::REG_CHECK_MODE: cfg_in.check_mode = csr_data[0];
            bpf_pkg::REG_QUOTE_ALL:  cfg_in.quote_all  = csr_data[0];
            bpf_pkg::REG_MASK_LOW:   cfg_in.mask_low   = csr_data;
            bpf_pkg::REG_MASK_HIGH:  cfg_in.mask_high  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      digit_char = bpf_pkg::CH_ZERO + {4'h0, seq_digit};
      acc0 = first_of_packet ? (cfg_ff.check_mode ? bpf_pkg::CRC_INIT : '0) : acc_ff;
      acc1 = first_of_packet ? bpf_pkg::chk_update(acc0, digit_char, cfg_ff.check_mode)
                             : acc0;
      acc2 = bpf_pkg::chk_update(acc1, payload_byte, cfg_ff.check_mode);
      acc3 = last_of_packet ? bpf_pkg::chk_update(acc2, bpf_pkg::CH_ETX, cfg_ff.check_mode)
                            : acc2;
      acc_in = accept ? acc3 : acc_ff;
   end

   assign dat_esc = bpf_pkg::esc_need(payload_byte, cfg_ff);
   assign hi_esc  = bpf_pkg::esc_need(acc3[15:8], cfg_ff);
   assign lo_esc  = bpf_pkg::esc_need(acc3[7:0], cfg_ff);

   always_comb begin
      push_job.first      = first_of_packet;
      push_job.digit_char = digit_char;
      push_job.dat        = bpf_pkg::esc_value(payload_byte, dat_esc);
      push_job.dat_esc    = dat_esc;
      push_job.last       = last_of_packet;
      push_job.crc        = cfg_ff.check_mode;
      push_job.chk_hi     = bpf_pkg::esc_value(acc3[15:8], hi_esc);
      push_job.hi_esc     = hi_esc;
      push_job.chk_lo     = bpf_pkg::esc_value(acc3[7:0], lo_esc);
      push_job.lo_esc     = lo_esc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_mode <= 1'b0;
         cfg_ff.quote_all  <= 1'b0;
         cfg_ff.mask_low   <= bpf_pkg::MASK_LOW_RESET;
         cfg_ff.mask_high  <= bpf_pkg::MASK_HIGH_RESET;
         acc_ff            <= '0;
      end else begin
         cfg_ff <= cfg_in;
         acc_ff <= acc_in;
      end
   end

endmodule

/* rtl/bpf_queue.sv */
// Small request queue between front and back end.
module bpf_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bpf_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop,
   output bpf_pkg::job_type pop_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bpf_pkg::job_type  mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/bpf_back.sv */
// Back end: walks the output slots of each request, one line byte per cycle unless stalled.
module bpf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_pop,
   input  bpf_pkg::job_type            job,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bpf_pkg::BYTE_W-1:0]  tx_byte,
   output logic                        run_last,
   output logic                        frame_end
);

   bpf_pkg::job_type             cur_ff, cur_in;
   bpf_pkg::slot_mask_type       mask_ff, mask_in;
   bpf_pkg::slot_mask_type       enables, pick, rem;
   logic [bpf_pkg::BYTE_W-1:0]   slot_byte [bpf_pkg::NUM_SLOTS];
   logic [bpf_pkg::BYTE_W-1:0]   sel_byte;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bpf_pkg::BYTE_W-1:0]   tx_byte_ff;
   logic                         run_last_ff, frame_end_ff;
   logic                         busy, out_free, advance, need_load;

   always_comb begin
      enables = '0;
      enables[bpf_pkg::SLOT_HDR_DLE] = job.first;
      enables[bpf_pkg::SLOT_HDR_B]   = job.first;
      enables[bpf_pkg::SLOT_DIGIT]   = job.first;
      enables[bpf_pkg::SLOT_DAT_DLE] = job.dat_esc;
      enables[bpf_pkg::SLOT_DAT]     = 1'b1;
      enables[bpf_pkg::SLOT_ETX]     = job.last;
      enables[bpf_pkg::SLOT_HI_DLE]  = job.last && job.crc && job.hi_esc;
      enables[bpf_pkg::SLOT_HI]      = job.last && job.crc;
      enables[bpf_pkg::SLOT_LO_DLE]  = job.last && job.lo_esc;
      enables[bpf_pkg::SLOT_LO]      = job.last;
   end

   always_comb begin
      slot_byte[bpf_pkg::SLOT_HDR_DLE] = bpf_pkg::CH_DLE;
      slot_byte[bpf_pkg::SLOT_HDR_B]   = bpf_pkg::CH_B;
      slot_byte[bpf_pkg::SLOT_DIGIT]   = cur_ff.digit_char;
      slot_byte[bpf_pkg::SLOT_DAT_DLE] = bpf_pkg::CH_DLE;
      slot_byte[bpf_pkg::SLOT_DAT]     = cur_ff.dat;
      slot_byte[bpf_pkg::SLOT_ETX]     = bpf_pkg::CH_ETX;
      slot_byte[bpf_pkg::SLOT_HI_DLE]  = bpf_pkg::CH_DLE;
      slot_byte[bpf_pkg::SLOT_HI]      = cur_ff.chk_hi;
      slot_byte[bpf_pkg::SLOT_LO_DLE]  = bpf_pkg::CH_DLE;
      slot_byte[bpf_pkg::SLOT_LO]      = cur_ff.chk_lo;
   end

   // lowest pending slot goes out next
   always_comb begin
      pick     = mask_ff & (~mask_ff + 1'b1);
      rem      = mask_ff & ~pick;
      sel_byte = '0;
      for (int i = 0; i < bpf_pkg::NUM_SLOTS; i++) begin
         sel_byte = sel_byte | (pick[i] ? slot_byte[i] : '0);
      end
   end

   assign busy      = (mask_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = busy && out_free;
   assign need_load = !busy || (advance && (rem == '0));
   assign job_pop   = need_load && job_valid;

   always_comb begin
      cur_in  = job_pop ? job : cur_ff;
      mask_in = mask_ff;
      if (job_pop) begin
         mask_in = enables;
      end else if (advance) begin
         mask_in = rem;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         tx_byte_ff   <= sel_byte;
         run_last_ff  <= (rem == '0);
         frame_end_ff <= (rem == '0) && cur_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign tx_byte   = tx_byte_ff;
   assign run_last  = run_last_ff;
   assign frame_end = frame_end_ff;

endmodule

/* rtl/b_plus_packet_framer.sv */
// Top level of the packet framer: front end, request queue and back end.
//
// Channel  Dir  Handshake      Carries
// req_if   in   valid/ready    payload_byte, first_of_packet, last_of_packet, seq_digit
// rsp_if   out  valid/ready    tx_byte, run_last, frame_end
// csr_if   in   valid/ready    index, data (check_mode, quote_all, mask_low, mask_high)
//
// One line byte leaves per cycle while the output is not stalled; a request makes 1 to 10
// output bytes in the back end, one per enabled slot, which sets the sustained rate.
// Check and escape decisions are made in the cycle a request is accepted.
// The queue of QUEUE_DEPTH entries and the output register let each side stall alone.
// Synchronous reset clears queue, sequencer and output valid; CSR always ready.
module b_plus_packet_framer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   bpf_req_if.sink     req_if,
   bpf_rsp_if.source   rsp_if,
   bpf_csr_if.sink     csr_if
);

   bpf_pkg::job_type  push_job, pop_job;
   logic              push_valid, push_ready;
   logic              pop_valid, pop;

   bpf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .payload_byte    (req_if.payload_byte),
      .first_of_packet (req_if.first_of_packet),
      .last_of_packet  (req_if.last_of_packet),
      .seq_digit       (req_if.seq_digit),
      .csr_valid       (csr_if.valid),
      .csr_ready       (csr_if.ready),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_job        (push_job)
   );

   bpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   bpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_pop   (pop),
      .job       (pop_job),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .tx_byte   (rsp_if.tx_byte),
      .run_last  (rsp_if.run_last),
      .frame_end (rsp_if.frame_end)
   );

endmodule

/* rtl/bpf_checker.sv */
// Port-level checks of the packet framer, bound to the top level.
`include "assert_macros.svh"

module bpf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bpf_pkg::BYTE_W-1:0]  tx_byte,
   input logic                        run_last,
   input logic                        frame_end
);

   `BPF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(run_last) && $stable(frame_end), "stalled response changed")
   `BPF_ASSERT(a_end_is_last, clock, reset, rsp_valid && frame_end |-> run_last, "frame_end without run_last")
   `BPF_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "bad state after reset")

endmodule

bind b_plus_packet_framer bpf_checker u_bpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .tx_byte   (rsp_if.tx_byte),
   .run_last  (rsp_if.run_last),
   .frame_end (rsp_if.frame_end)
);

/* bench/testbench.sv */
// Self-checking bench for the packet framer: directed table, then random packets.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 33;
   localparam int IDLE_PCT     = 27;
   localparam int HOLD_AT      = 140;
   localparam int HOLD_CYCLES  = 120;
   localparam int SETTLE       = 20;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [bpf_pkg::BYTE_W-1:0]  payload;
      logic                        first;
      logic                        last;
      logic [bpf_pkg::DIGIT_W-1:0] digit;
   } frame_req_type;

   typedef struct packed {
      logic [bpf_pkg::BYTE_W-1:0] tx_byte;
      logic                       run_last;
      logic                       frame_end;
   } line_byte_type;

   typedef struct {
      row_kind_type                  kind;
      frame_req_type                 req;
      int                            n_typed;
      logic [31:0]                   typed;
      logic [bpf_pkg::CSR_IDX_W-1:0] csr_index;
      logic [bpf_pkg::CSR_DAT_W-1:0] csr_data;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   bpf_req_if req_ch ();
   bpf_rsp_if rsp_ch ();
   bpf_csr_if csr_ch ();

   b_plus_packet_framer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #5 clock = ~clock;

   // framer model state
   logic                       cfg_crc       = 1'b0;
   logic                       cfg_quote_all = 1'b0;
   logic [bpf_pkg::MASK_W-1:0] cfg_mask_low  = bpf_pkg::MASK_LOW_RESET;
   logic [bpf_pkg::MASK_W-1:0] cfg_mask_high = bpf_pkg::MASK_HIGH_RESET;
   logic [bpf_pkg::ACC_W-1:0]  check_acc     = '0;

   logic [bpf_pkg::BYTE_W-1:0] framed_bytes[$];
   line_byte_type              expected_line[$];
   dir_row_type                dir_rows[$];

   int   req_accepted = 0;
   int   fail_count   = 0;
   int   cycle_count  = 0;
   logic rsp_hold;

   function automatic logic [bpf_pkg::ACC_W-1:0] fold_check(
         logic [bpf_pkg::ACC_W-1:0] acc, logic [bpf_pkg::BYTE_W-1:0] b);
      logic [bpf_pkg::ACC_W-1:0] c;
      int                        a;
      if (cfg_crc) begin
         c = acc ^ {b, 8'h00};
         repeat (8) c = c[bpf_pkg::ACC_W-1] ? ((c << 1) ^ bpf_pkg::CRC_POLY) : (c << 1);
         return c;
      end
      a = int'(acc[7:0]) * 2;
      if (a > 255) a = a - 255;
      a = a + int'(b);
      if (a > 255) a = a - 255;
      return bpf_pkg::ACC_W'(a);
   endfunction

   function automatic void put_escaped(logic [bpf_pkg::BYTE_W-1:0] b);
      if (b < 8'h20 && (cfg_quote_all || cfg_mask_low[b[4:0]])) begin
         framed_bytes.push_back(bpf_pkg::CH_DLE);
         framed_bytes.push_back(b + bpf_pkg::LOW_ADJ);
      end else if (b >= 8'h80 && b < 8'hA0 && (cfg_quote_all || cfg_mask_high[b[4:0]])) begin
         framed_bytes.push_back(bpf_pkg::CH_DLE);
         framed_bytes.push_back(b - bpf_pkg::HIGH_ADJ);
      end else begin
         framed_bytes.push_back(b);
      end
   endfunction

   function automatic void frame_request(frame_req_type r);
      logic [bpf_pkg::BYTE_W-1:0] digit_char;
      framed_bytes.delete();
      if (r.first) begin
         digit_char = bpf_pkg::CH_ZERO + {4'b0000, r.digit};
         check_acc  = cfg_crc ? bpf_pkg::CRC_INIT : '0;
         framed_bytes.push_back(bpf_pkg::CH_DLE);
         framed_bytes.push_back(bpf_pkg::CH_B);
         framed_bytes.push_back(digit_char);
         check_acc = fold_check(check_acc, digit_char);
      end
      put_escaped(r.payload);
      check_acc = fold_check(check_acc, r.payload);
      if (r.last) begin
         framed_bytes.push_back(bpf_pkg::CH_ETX);
         check_acc = fold_check(check_acc, bpf_pkg::CH_ETX);
         if (cfg_crc) put_escaped(check_acc[15:8]);
         put_escaped(check_acc[7:0]);
      end
   endfunction

   function automatic void add_req_row(logic [bpf_pkg::BYTE_W-1:0] payload, logic first,
                                       logic last, logic [bpf_pkg::DIGIT_W-1:0] digit,
                                       int n_typed, logic [31:0] typed);
      dir_row_type row;
      row.kind      = ROW_REQ;
      row.req       = '{payload: payload, first: first, last: last, digit: digit};
      row.n_typed   = n_typed;
      row.typed     = typed;
      row.csr_index = '0;
      row.csr_data  = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr_row(logic [bpf_pkg::CSR_IDX_W-1:0] index,
                                       logic [bpf_pkg::CSR_DAT_W-1:0] data);
      dir_row_type row;
      row.kind      = ROW_CSR;
      row.req       = '0;
      row.n_typed   = 0;
      row.typed     = '0;
      row.csr_index = index;
      row.csr_data  = data;
      dir_rows.push_back(row);
   endfunction

   function automatic logic calm_window();
      return req_accepted >= 110 && req_accepted < 170;
   endfunction

   function automatic logic [bpf_pkg::BYTE_W-1:0] rand_payload();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return bpf_pkg::BYTE_W'($urandom_range(8'h00, 8'h1F));
      if (pick < 7) return bpf_pkg::BYTE_W'($urandom_range(8'h80, 8'h9F));
      return bpf_pkg::BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [bpf_pkg::MASK_W-1:0] rand_mask();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return bpf_pkg::MASK_LOW_RESET;
         default: return bpf_pkg::MASK_W'($urandom);
      endcase
   endfunction

   // typed: expected line bytes, first byte in the most significant used position
   task automatic send_request(input frame_req_type r, input int n_typed,
                               input logic [31:0] typed);
      int n;
      logic [bpf_pkg::BYTE_W-1:0] b;
      while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.payload_byte    <= r.payload;
      req_ch.first_of_packet <= r.first;
      req_ch.last_of_packet  <= r.last;
      req_ch.seq_digit       <= r.digit;
      do @(posedge clock); while (!req_ch.ready);
      req_accepted++;
      frame_request(r);
      if (n_typed != 0) begin
         framed_bytes.delete();
         for (int i = 0; i < n_typed; i++)
            framed_bytes.push_back(typed[bpf_pkg::BYTE_W * (n_typed - 1 - i) +: bpf_pkg::BYTE_W]);
      end
      n = framed_bytes.size();
      for (int i = 0; i < n; i++) begin
         b = framed_bytes[i];
         expected_line.push_back('{tx_byte: b, run_last: i == n - 1,
                                   frame_end: r.last && i == n - 1});
      end
   endtask

   task automatic finish_burst();
      req_ch.valid <= 1'b0;
      while (expected_line.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [bpf_pkg::CSR_IDX_W-1:0] index,
                            input logic [bpf_pkg::CSR_DAT_W-1:0] data, input logic more);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (!more) csr_ch.valid <= 1'b0;
      case (index)
         bpf_pkg::REG_CHECK_MODE: cfg_crc       = data[0];
         bpf_pkg::REG_QUOTE_ALL:  cfg_quote_all = data[0];
         bpf_pkg::REG_MASK_LOW:   cfg_mask_low  = data;
         bpf_pkg::REG_MASK_HIGH:  cfg_mask_high = data;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: check, then pick ready for the next cycle
   initial begin
      line_byte_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_line.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected line byte %h run_last %b frame_end %b",
                           rsp_ch.tx_byte, rsp_ch.run_last, rsp_ch.frame_end);
            end else begin
               want = expected_line.pop_front();
               if (rsp_ch.tx_byte !== want.tx_byte || rsp_ch.run_last !== want.run_last ||
                   rsp_ch.frame_end !== want.frame_end) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                              want.tx_byte, want.run_last, want.frame_end,
                              rsp_ch.tx_byte, rsp_ch.run_last, rsp_ch.frame_end);
               end
            end
         end
         rsp_ch.ready <= !rsp_hold && (calm_window() || $urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // back-pressure: hold the line side off long enough to fill the block
   initial begin
      rsp_hold = 1'b0;
      wait (req_accepted >= HOLD_AT);
      @(posedge clock);
      rsp_hold <= 1'b1;
      for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      logic                       cm;
      logic                       qa;
      logic [bpf_pkg::MASK_W-1:0] ml;
      logic [bpf_pkg::MASK_W-1:0] mh;
      int                         count;
      int                         len;
      frame_req_type              r;
      logic                       more;

      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.payload_byte    = '0;
      req_ch.first_of_packet = 1'b0;
      req_ch.last_of_packet  = 1'b0;
      req_ch.seq_digit       = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = '0;
      csr_ch.data            = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // bytes outside any packet and short packets, reset masks
      add_req_row(8'h00, 1'b0, 1'b0, 4'd0, 1, 32'h00);
      add_req_row(8'h03, 1'b0, 1'b0, 4'd0, 2, 32'h1043);
      add_req_row(8'h10, 1'b0, 1'b0, 4'd0, 2, 32'h1050);
      add_req_row(8'hFF, 1'b0, 1'b0, 4'd0, 1, 32'hFF);
      add_req_row(8'h80, 1'b0, 1'b0, 4'd0, 1, 32'h80);
      add_req_row(8'h9F, 1'b0, 1'b0, 4'd0, 1, 32'h9F);
      add_req_row(8'h1F, 1'b0, 1'b0, 4'd0, 1, 32'h1F);
      add_req_row(8'h11, 1'b0, 1'b1, 4'd0, 0, 32'h0);
      add_req_row(8'h41, 1'b1, 1'b0, 4'd0, 4, 32'h10423041);
      add_req_row(8'h13, 1'b0, 1'b1, 4'd0, 0, 32'h0);
      add_req_row(8'h15, 1'b1, 1'b1, 4'd9, 0, 32'h0);
      // digit out of range, packet left open across a mode change
      add_req_row(8'h00, 1'b1, 1'b0, 4'd15, 4, 32'h10423F00);
      add_csr_row(bpf_pkg::REG_CHECK_MODE, 32'd1);
      add_req_row(8'h20, 1'b0, 1'b1, 4'd0, 0, 32'h0);
      add_req_row(8'h7F, 1'b1, 1'b1, 4'd10, 0, 32'h0);
      add_csr_row(bpf_pkg::REG_QUOTE_ALL, 32'd1);
      add_req_row(8'h00, 1'b0, 1'b0, 4'd0, 2, 32'h1040);
      add_req_row(8'h1F, 1'b0, 1'b0, 4'd0, 2, 32'h105F);
      add_req_row(8'h80, 1'b0, 1'b0, 4'd0, 2, 32'h1060);
      add_req_row(8'h9F, 1'b0, 1'b0, 4'd0, 2, 32'h107F);
      add_req_row(8'hA0, 1'b0, 1'b0, 4'd0, 1, 32'hA0);
      add_req_row(8'h20, 1'b0, 1'b1, 4'd0, 0, 32'h0);
      add_csr_row(bpf_pkg::REG_QUOTE_ALL, 32'd0);
      add_csr_row(bpf_pkg::REG_MASK_LOW, 32'h0000_0000);
      add_csr_row(bpf_pkg::REG_MASK_HIGH, 32'hFFFF_FFFF);
      add_req_row(8'h03, 1'b0, 1'b0, 4'd0, 1, 32'h03);
      add_req_row(8'h85, 1'b1, 1'b1, 4'd5, 0, 32'h0);
      add_csr_row(bpf_pkg::REG_CHECK_MODE, 32'd0);
      add_req_row(8'h9A, 1'b1, 1'b1, 4'd3, 0, 32'h0);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            if (i == 0 || dir_rows[i-1].kind == ROW_REQ) finish_burst();
            more = (i + 1 < dir_rows.size()) && dir_rows[i+1].kind == ROW_CSR;
            csr_write(dir_rows[i].csr_index, dir_rows[i].csr_data, more);
         end else begin
            send_request(dir_rows[i].req, dir_rows[i].n_typed, dir_rows[i].typed);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         finish_burst();
         case (p)
            0: begin cm = 1'b0; qa = 1'b0; ml = '0; mh = '0; end
            1: begin cm = 1'b1; qa = 1'b1; ml = '1; mh = '1; end
            2: begin cm = 1'b0; qa = 1'b0; ml = '1; mh = '1; end
            3: begin cm = 1'b1; qa = 1'b0; ml = '0; mh = '0; end
            default: begin
               cm = 1'($urandom_range(0, 1));
               qa = ($urandom_range(0, 3) == 0);
               ml = rand_mask();
               mh = rand_mask();
            end
         endcase
         csr_write(bpf_pkg::REG_CHECK_MODE, {31'b0, cm}, 1'b1);
         csr_write(bpf_pkg::REG_QUOTE_ALL, {31'b0, qa}, 1'b1);
         csr_write(bpf_pkg::REG_MASK_LOW, ml, 1'b1);
         csr_write(bpf_pkg::REG_MASK_HIGH, mh, 1'b0);

         count = 0;
         while (count < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
               r.payload = rand_payload();
               r.first   = 1'($urandom_range(0, 1));
               r.last    = 1'($urandom_range(0, 1));
               r.digit   = bpf_pkg::DIGIT_W'($urandom_range(0, 15));
               send_request(r, 0, 32'h0);
               count++;
            end else begin
               len     = $urandom_range(1, 6);
               r.digit = ($urandom_range(0, 7) == 0) ?
                         bpf_pkg::DIGIT_W'($urandom_range(10, 15)) :
                         bpf_pkg::DIGIT_W'($urandom_range(0, 9));
               for (int k = 0; k < len; k++) begin
                  r.payload = rand_payload();
                  r.first   = (k == 0);
                  r.last    = (k == len - 1);
                  send_request(r, 0, 32'h0);
                  count++;
               end
            end
         end
      end

      finish_burst();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
